// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define RDI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition implies a property in the next clock cycle.
`define RDI_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ===== hw/rtl/rdi_pkg.sv =====
package rdi_pkg;

    localparam int FUNC_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 6;
    localparam int LEN_W     = POS_W + 1;
    localparam int LEN_LIMIT = 64;
    localparam int ADDR_EXT_W = 12;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH     = 3'd0,
        FN_POP_HEAD = 3'd1,
        FN_POP_TAIL = 3'd2,
        FN_READ     = 3'd3,
        FN_WRITE    = 3'd4,
        FN_SWAP     = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SWAP_A,
        ST_SWAP_B
    } t_state;

endpackage

// ===== hw/rtl/rdi_if.sv =====
interface rdi_req_if;
    import rdi_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   index_a;
    logic [POS_W-1:0]   index_b;

    modport source (output valid, func, value, index_a, index_b, input ready);
    modport sink   (input valid, func, value, index_a, index_b, output ready);
endinterface

interface rdi_rsp_if;
    import rdi_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]   count_now;

    modport source (output valid, status, read_value, count_now, input ready);
    modport sink   (input valid, status, read_value, count_now, output ready);
endinterface

// ===== hw/rtl/rdi_store.sv =====
module rdi_store #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [WORD_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr_a,
    input  logic [AW-1:0]         i_rd_addr_b,
    output logic [WORD_WIDTH-1:0] o_rd_data_a,
    output logic [WORD_WIDTH-1:0] o_rd_data_b
);

    logic [WORD_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= mem[i_rd_addr_a];
            o_rd_data_b <= mem[i_rd_addr_b];
        end
    end

endmodule

// ===== hw/rtl/ring_deque_indexed.sv =====
// Channel   Direction  Word
// i_req     in         func, value, index_a, index_b
// o_rsp     out        status, read_value, count_now
// i_cfg_*   in         capacity write, empties the queue
//
// Push, write and every refused request are answered from the idle state; pops and reads
// pass through the read state, as the store registers its read data; a swap passes through
// its two write-back states, swap A and swap B, through the single store write port.
// A new word is taken only in the idle state, which keeps accesses to one entry apart.
// Reset is synchronous; pointers and count go to zero and the capacity to 63.
// A word is accepted while the output register is empty or being emptied.
`include "assert_macros.svh"

module ring_deque_indexed #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [rdi_pkg::POS_W-1:0] i_cfg_wr_data,
    rdi_req_if.sink                 i_req,
    rdi_rsp_if.source               o_rsp
);
    import rdi_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int LEN_MAX = (DEPTH < LEN_LIMIT) ? DEPTH : LEN_LIMIT;

    t_state              r_state, n_state;
    logic [POS_W-1:0]    r_cap, n_cap;
    logic [POS_W-1:0]    r_head, n_head;
    logic [POS_W-1:0]    r_tail, n_tail;
    logic [POS_W-1:0]    r_held, n_held;
    logic                r_out_valid, n_out_valid;
    logic                r_status, n_status;
    logic [VALUE_W-1:0]  r_rdata, n_rdata;
    logic [POS_W-1:0]    r_count, n_count;
    logic [AW-1:0]       r_addr_a, n_addr_a;
    logic [AW-1:0]       r_addr_b, n_addr_b;
    logic [WORD_WIDTH-1:0] r_hold, n_hold;

    logic [LEN_W-1:0]    cap_inc, len, len_m1, tail_inc, head_inc, pa_sum, pb_sum, ring_sum;
    logic [POS_W-1:0]    tail_next, head_next, tail_prev, pa, pb;
    logic                full, ia_ok, ib_ok, accept, req_ok, mem_read;

    logic                  wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr_a, rd_addr_b;
    logic [WORD_WIDTH-1:0] wr_data, rd_data_a, rd_data_b;

    function automatic logic [AW-1:0] to_addr(input logic [POS_W-1:0] p);
        logic [ADDR_EXT_W-1:0] ext;
        ext = ADDR_EXT_W'(p);
        return ext[AW-1:0];
    endfunction

    rdi_store #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .AW         (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    assign cap_inc   = LEN_W'(r_cap) + LEN_W'(1);
    assign len       = (cap_inc > LEN_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : cap_inc;
    assign len_m1    = len - LEN_W'(1);
    assign tail_inc  = LEN_W'(r_tail) + LEN_W'(1);
    assign head_inc  = LEN_W'(r_head) + LEN_W'(1);
    assign tail_next = (tail_inc == len) ? '0 : tail_inc[POS_W-1:0];
    assign head_next = (head_inc == len) ? '0 : head_inc[POS_W-1:0];
    assign tail_prev = (r_tail == '0) ? len_m1[POS_W-1:0] : r_tail - POS_W'(1);
    assign full      = (tail_next == r_head);

    // An index below the count keeps head plus index under twice the ring length.
    assign pa_sum = LEN_W'(r_head) + LEN_W'(i_req.index_a);
    assign pb_sum = LEN_W'(r_head) + LEN_W'(i_req.index_b);
    assign pa     = (pa_sum >= len) ? POS_W'(pa_sum - len) : pa_sum[POS_W-1:0];
    assign pb     = (pb_sum >= len) ? POS_W'(pb_sum - len) : pb_sum[POS_W-1:0];
    assign ia_ok  = (i_req.index_a < r_held);
    assign ib_ok  = (i_req.index_b < r_held);

    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.read_value = r_rdata;
    assign o_rsp.count_now  = r_count;

    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_head      = r_head;
        n_tail      = r_tail;
        n_held      = r_held;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_rdata     = r_rdata;
        n_count     = r_count;
        n_addr_a    = r_addr_a;
        n_addr_b    = r_addr_b;
        n_hold      = r_hold;
        req_ok      = 1'b0;
        mem_read    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = to_addr(r_tail);
        wr_data     = WORD_WIDTH'(i_req.value);
        rd_en       = 1'b0;
        rd_addr_a   = to_addr(pa);
        rd_addr_b   = to_addr(pb);

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_func'(i_req.func))
                        FN_PUSH: begin
                            if (!full) begin
                                req_ok  = 1'b1;
                                wr_en   = 1'b1;
                                n_tail  = tail_next;
                                n_held  = r_held + POS_W'(1);
                            end
                        end
                        FN_POP_HEAD: begin
                            if (r_held != '0) begin
                                req_ok    = 1'b1;
                                mem_read  = 1'b1;
                                rd_en     = 1'b1;
                                rd_addr_a = to_addr(r_head);
                                n_head    = head_next;
                                n_held    = r_held - POS_W'(1);
                                n_state   = ST_READ;
                            end
                        end
                        FN_POP_TAIL: begin
                            if (r_held != '0) begin
                                req_ok    = 1'b1;
                                mem_read  = 1'b1;
                                rd_en     = 1'b1;
                                rd_addr_a = to_addr(tail_prev);
                                n_tail    = tail_prev;
                                n_held    = r_held - POS_W'(1);
                                n_state   = ST_READ;
                            end
                        end
                        FN_READ: begin
                            if (ia_ok) begin
                                req_ok   = 1'b1;
                                mem_read = 1'b1;
                                rd_en    = 1'b1;
                                n_state  = ST_READ;
                            end
                        end
                        FN_WRITE: begin
                            if (ia_ok) begin
                                req_ok  = 1'b1;
                                wr_en   = 1'b1;
                                wr_addr = to_addr(pa);
                            end
                        end
                        FN_SWAP: begin
                            if (ia_ok && ib_ok) begin
                                req_ok   = 1'b1;
                                mem_read = 1'b1;
                                rd_en    = 1'b1;
                                n_addr_a = to_addr(pa);
                                n_addr_b = to_addr(pb);
                                n_state  = ST_SWAP_A;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (!mem_read) begin
                        n_out_valid = 1'b1;
                        n_status    = !req_ok;
                        n_rdata     = '0;
                        n_count     = n_held;
                    end
                end
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_status    = 1'b0;
                n_rdata     = VALUE_W'(rd_data_a);
                n_count     = r_held;
                n_state     = ST_IDLE;
            end
            ST_SWAP_A: begin
                wr_en   = 1'b1;
                wr_addr = r_addr_a;
                wr_data = rd_data_b;
                n_hold  = rd_data_a;
                n_state = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                wr_en       = 1'b1;
                wr_addr     = r_addr_b;
                wr_data     = r_hold;
                n_out_valid = 1'b1;
                n_status    = 1'b0;
                n_rdata     = '0;
                n_count     = r_held;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_wr_en) begin
            n_cap  = i_cfg_wr_data;
            n_head = '0;
            n_tail = '0;
            n_held = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= POS_W'(LEN_LIMIT - 1);
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rdata  <= n_rdata;
        r_count  <= n_count;
        r_addr_a <= n_addr_a;
        r_addr_b <= n_addr_b;
        r_hold   <= n_hold;
    end

    assign ring_sum = LEN_W'(r_head) + LEN_W'(r_held);

    `RDI_ASSERT(a_held_below_len, i_clk, i_rst_n, LEN_W'(r_held) < len, "count reached ring length")
    `RDI_ASSERT(a_ring_consistent, i_clk, i_rst_n, ((ring_sum >= len) ? ring_sum - len : ring_sum) == LEN_W'(r_tail), "head plus count does not meet tail")
    `RDI_ASSERT_NEXT(a_read_delivers, i_clk, i_rst_n, r_state == ST_READ, r_out_valid && r_state == ST_IDLE, "read result not loaded")
    `RDI_ASSERT_NEXT(a_swap_order, i_clk, i_rst_n, r_state == ST_SWAP_A, r_state == ST_SWAP_B && !i_req.ready, "swap write-back order broken")

endmodule
